>>> hw/rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, constants and helpers for the first-free bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int MAP_BITS   = 8192;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ENTRY_W    = $clog2(MAP_BITS);
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int NUM_W      = 14;
  localparam int CFG_IDX_W  = 1;

  localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(8192);

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    POOL_INODE = 1'b0,
    POOL_BLOCK = 1'b1
  } pool_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_DOUBLE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INODE_LIMIT = 1'b0,
    REG_BLOCK_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_FCHK
  } state_t;

  typedef struct packed {
    logic             mode;
    logic             pool;
    logic [NUM_W-1:0] entry_number;
  } alloc_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] granted_number;
    logic [1:0]       status;
    logic [NUM_W-1:0] free_left;
  } alloc_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;    // capture request beat
    logic    rd_en;    // issue map read, advance scan pointer
    logic    commit;   // write map word and update used count
    logic    respond;  // load result registers
    status_t status;
  } bffa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic lim_zero;
    logic range_ok;
    logic hit;        // clear bit found in current scan word
    logic last_word;  // current scan word is the last below the limit
    logic bit_set;    // entry to free is currently set
  } bffa_sts_t;

  // index of lowest set bit; caller checks the word is non-zero
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_IDX_W'(i);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bffa_bitmap.sv
// ----------------------------------------------------------------------------
// bffa_bitmap
// One allocation bitmap: word memory with per-word valid bits, registered read.
// ----------------------------------------------------------------------------
module bffa_bitmap
  import bffa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [WORD_IDX_W-1:0] rd_addr,
  output logic [WORD_BITS-1:0]  rd_data,
  input  logic                  wr_en,
  input  logic [WORD_IDX_W-1:0] wr_addr,
  input  logic [WORD_BITS-1:0]  wr_data
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld;
  logic [WORD_BITS-1:0] q_raw;
  logic                 q_vld;

  // never-written words read as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_raw <= mem[rd_addr];
    q_vld <= vld[rd_addr];
  end

  assign rd_data = q_vld ? q_raw : '0;

endmodule

>>> hw/rtl/bffa_datapath.sv
// ----------------------------------------------------------------------------
// bffa_datapath
// Limit registers, request latch, both bitmaps, used counters and result regs.
// ----------------------------------------------------------------------------
module bffa_datapath
  import bffa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  alloc_req_t           req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NUM_W-1:0]     cfg_data,
  input  bffa_cmd_t            cmd,
  output bffa_sts_t            sts,
  output logic                 done,
  output alloc_rsp_t           rsp
);

  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  logic [NUM_W-1:0] inode_limit;
  logic [NUM_W-1:0] block_limit;
  logic [NUM_W-1:0] inodes_used;
  logic [NUM_W-1:0] blocks_used;

  logic             mode_r;
  logic             pool_r;
  logic [NUM_W-1:0] num_r;

  logic [WORD_IDX_W-1:0] scan_word;
  logic [WORD_IDX_W-1:0] q_word;

  logic [NUM_W-1:0]      lim_raw, lim_eff, lim_m1;
  logic [NUM_W-1:0]      idx_full;
  logic [ENTRY_W-1:0]    idx;
  logic [WORD_IDX_W-1:0] idx_word, last_word, rd_addr;
  logic [BIT_IDX_W-1:0]  idx_bit, last_bit, sh, hit_bit;
  logic [WORD_BITS-1:0]  q_inode, q_block, q, mask, cand, wr_data;
  logic [ENTRY_W-1:0]    hit_idx;
  logic [NUM_W-1:0]      grant;
  logic [NUM_W-1:0]      used_sel, used_after, free_left;
  logic                  is_alloc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      inode_limit <= LIMIT_RESET;
      block_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INODE_LIMIT: inode_limit <= cfg_data;
        REG_BLOCK_LIMIT: block_limit <= cfg_data;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= req.mode;
      pool_r <= req.pool;
      num_r  <= req.entry_number;
    end
  end

  assign is_alloc = (mode_r == MODE_ALLOC);

  // limits and addressing
  assign lim_raw   = (pool_r == POOL_BLOCK) ? block_limit : inode_limit;
  assign lim_eff   = (lim_raw > NUM_W'(MAP_BITS)) ? NUM_W'(MAP_BITS) : lim_raw;
  assign lim_m1    = lim_eff - NUM_W'(1);
  assign last_word = lim_m1[ENTRY_W-1:BIT_IDX_W];
  assign last_bit  = lim_m1[BIT_IDX_W-1:0];

  assign idx_full  = (pool_r == POOL_BLOCK) ? num_r : num_r - NUM_W'(1);
  assign idx       = idx_full[ENTRY_W-1:0];
  assign idx_word  = idx[ENTRY_W-1:BIT_IDX_W];
  assign idx_bit   = idx[BIT_IDX_W-1:0];

  assign rd_addr   = is_alloc ? scan_word : idx_word;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      scan_word <= '0;
    end else if (cmd.rd_en) begin
      scan_word <= scan_word + WORD_IDX_W'(1);
    end
    if (cmd.rd_en) begin
      q_word <= rd_addr;
    end
  end

  // maps
  bffa_bitmap u_inode_map (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (q_inode),
    .wr_en   (cmd.commit && (pool_r == POOL_INODE)),
    .wr_addr (q_word),
    .wr_data (wr_data)
  );

  bffa_bitmap u_block_map (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (q_block),
    .wr_en   (cmd.commit && (pool_r == POOL_BLOCK)),
    .wr_addr (q_word),
    .wr_data (wr_data)
  );

  assign q = (pool_r == POOL_BLOCK) ? q_block : q_inode;

  // clear-bit search in the word just read; last word masked to the limit
  assign sh      = BIT_IDX_W'(WORD_BITS - 1) - last_bit;
  assign mask    = (q_word == last_word) ? (ALL_ONES >> sh) : ALL_ONES;
  assign cand    = ~q & mask;
  assign hit_bit = lowest_set(cand);
  assign hit_idx = {q_word, hit_bit};
  assign grant   = (pool_r == POOL_BLOCK) ? NUM_W'(hit_idx) : NUM_W'(hit_idx) + NUM_W'(1);

  assign wr_data = is_alloc ? (q | (WORD_BITS'(1) << hit_bit))
                            : (q & ~(WORD_BITS'(1) << idx_bit));

  // status to controller
  always_comb begin
    sts.is_free   = (mode_r == MODE_FREE);
    sts.lim_zero  = (lim_eff == '0);
    sts.range_ok  = (pool_r == POOL_BLOCK) ? (num_r < lim_eff)
                                           : ((num_r != '0) && (num_r <= lim_eff));
    sts.hit       = (cand != '0);
    sts.last_word = (q_word == last_word);
    sts.bit_set   = q[idx_bit];
  end

  // used counters
  assign used_sel = (pool_r == POOL_BLOCK) ? blocks_used : inodes_used;

  always_comb begin
    used_after = used_sel;
    if (cmd.commit) begin
      if (is_alloc) begin
        used_after = used_sel + NUM_W'(1);
      end else if (used_sel != '0) begin
        used_after = used_sel - NUM_W'(1);
      end
    end
  end

  assign free_left = (used_after >= lim_eff) ? '0 : lim_eff - used_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      inodes_used <= '0;
      blocks_used <= '0;
    end else if (cmd.commit) begin
      if (pool_r == POOL_BLOCK) begin
        blocks_used <= used_after;
      end else begin
        inodes_used <= used_after;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      rsp.granted_number <= (cmd.commit && is_alloc) ? grant : '0;
      rsp.status         <= cmd.status;
      rsp.free_left      <= free_left;
    end
  end

endmodule

>>> hw/rtl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer: accept, check, word scan or free check, commit and respond.
// ----------------------------------------------------------------------------
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  bffa_sts_t sts,
  output bffa_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_PREP;
      end
      S_PREP: begin
        if (sts.is_free) begin
          state_next = sts.range_ok ? S_FCHK : S_IDLE;
        end else begin
          state_next = sts.lim_zero ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.last_word) state_next = S_IDLE;
      end
      S_FCHK: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = STATUS_OK;
    unique case (state)
      S_IDLE: begin
        cmd.latch = start;
      end
      S_PREP: begin
        cmd.rd_en = 1'b1;
        if (sts.is_free && !sts.range_ok) begin
          cmd.respond = 1'b1;
          cmd.status  = STATUS_RANGE;
        end else if (!sts.is_free && sts.lim_zero) begin
          cmd.respond = 1'b1;
          cmd.status  = STATUS_FULL;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.hit) begin
          cmd.commit  = 1'b1;
          cmd.respond = 1'b1;
        end else if (sts.last_word) begin
          cmd.respond = 1'b1;
          cmd.status  = STATUS_FULL;
        end
      end
      S_FCHK: begin
        cmd.respond = 1'b1;
        if (sts.bit_set) begin
          cmd.commit = 1'b1;
        end else begin
          cmd.status = STATUS_DOUBLE;
        end
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> hw/rtl/bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over an inode bitmap and a block bitmap with counters.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a beat (mode, pool, entry_number) is taken on the edge
//   where start is high and busy is low. Allocate returns the lowest free
//   entry below the pool limit (inodes 1-based, blocks 0-based); free clears
//   the given entry. Every request gives exactly one result beat.
//   Result channel: done is high for one cycle with rsp valid; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 inode limit,
//   1 block limit) and cfg_data; cfg_ready is always high. Write only while
//   idle.
// Timing:
//   Allocation reads one 32-bit map word per cycle from the map memory,
//   from word 0 up to the first word with a clear bit or the last word
//   below the limit. Free reads and checks the entry's word; out of range
//   or zero limit requests end at the first check. done comes in the
//   cycle after busy falls, and the next request may be taken in it.
// Reset: both maps free (per-word valid bits cleared at once, no sweep),
//   counts zero, both limits 8192.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator
  import bffa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  alloc_req_t           req,
  output logic                 done,
  output alloc_rsp_t           rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NUM_W-1:0]     cfg_data
);

  bffa_cmd_t cmd;
  bffa_sts_t sts;

  // limits are plain registers, so every write is taken as it is offered
  assign cfg_ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bffa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .rsp       (rsp)
  );

endmodule
